/* hdl/sphe_pkg.sv */
package sphe_pkg;

    // Event kinds carried on the input tuser.
    typedef enum logic [1:0] {
        KIND_BALANCE = 2'd0,
        KIND_TEMP    = 2'd1,
        KIND_TICK    = 2'd2,
        KIND_STOP    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_ON   = 2'd1,
        CMD_OFF  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        CAUSE_NONE     = 3'd0,
        CAUSE_ON       = 3'd1,
        CAUSE_TEMP     = 3'd2,
        CAUSE_IMPORT   = 3'd3,
        CAUSE_BOTH     = 3'd4,
        CAUSE_WATCHDOG = 3'd5,
        CAUSE_STOP     = 3'd6
    } cause_t;

    // Configuration register indexes.
    localparam int unsigned CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] REG_SURPLUS_THRESHOLD = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMPORT_LIMIT      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_TEMP          = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CONFIRM_TIME      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_RUN           = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WATCHDOG          = 3'd5;

    typedef struct packed {
        logic signed [31:0] surplus_threshold_w;
        logic signed [31:0] import_limit_w;
        logic signed [31:0] max_temp_centi;
        logic        [31:0] confirm_time_ms;
        logic        [31:0] min_run_ms;
        logic        [31:0] watchdog_ms;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        surplus_threshold_w: -32'sd1000,
        import_limit_w:      32'sd200,
        max_temp_centi:      32'sd5500,
        confirm_time_ms:     32'd300000,
        min_run_ms:          32'd600000,
        watchdog_ms:         32'd60000
    };

    typedef struct packed {
        kind_t              kind;
        logic signed [31:0] value;
        logic        [31:0] now_ms;
    } event_t;

    typedef struct packed {
        cmd_t   relay_cmd;
        logic   heater_requested;
        cause_t cause;
    } result_t;

endpackage

/* hdl/sphe_cfg_regs.sv */
module sphe_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [sphe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                 cfg_data,
    output sphe_pkg::cfg_t              cfg
);
    import sphe_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SURPLUS_THRESHOLD: cfg_next.surplus_threshold_w = cfg_data;
                REG_IMPORT_LIMIT:      cfg_next.import_limit_w      = cfg_data;
                REG_MAX_TEMP:          cfg_next.max_temp_centi      = cfg_data;
                REG_CONFIRM_TIME:      cfg_next.confirm_time_ms     = cfg_data;
                REG_MIN_RUN:           cfg_next.min_run_ms          = cfg_data;
                REG_WATCHDOG:          cfg_next.watchdog_ms         = cfg_data;
                default:               cfg_next = cfg_reg;  // unused index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

/* hdl/sphe_rule_core.sv */
module sphe_rule_core (
    input  logic              clk,
    input  logic              rst_n,
    input  sphe_pkg::cfg_t    cfg,
    input  logic              step,
    input  sphe_pkg::event_t  ev,
    output sphe_pkg::result_t result,
    output logic              requested
);
    import sphe_pkg::*;

    logic               requested_reg,         requested_next;
    logic        [31:0] surplus_start_reg,     surplus_start_next;
    logic        [31:0] switch_on_reg,         switch_on_next;
    logic        [31:0] last_balance_time_reg, last_balance_time_next;
    logic signed [31:0] last_balance_reg,      last_balance_next;
    logic signed [31:0] last_temp_reg,         last_temp_next;

    logic signed [31:0] balance;
    logic signed [31:0] temp;
    logic        [31:0] start;
    logic        [31:0] since_start;
    logic        [31:0] since_on;
    logic        [31:0] since_balance;
    logic               surplus;
    logic               hot;
    logic               importing;
    logic               ran;

    // Values as seen after this event's report is taken in.
    assign balance = (ev.kind == KIND_BALANCE) ? ev.value : last_balance_reg;
    assign temp    = (ev.kind == KIND_TEMP)    ? ev.value : last_temp_reg;

    assign surplus     = balance <= cfg.surplus_threshold_w;
    // zero start time reads as "no start seen"
    assign start       = (surplus_start_reg == 32'd0) ? ev.now_ms : surplus_start_reg;
    assign since_start = ev.now_ms - start;
    assign since_on    = ev.now_ms - switch_on_reg;
    assign since_balance = ev.now_ms - last_balance_time_reg;
    assign hot         = temp >= cfg.max_temp_centi;
    assign importing   = balance >= cfg.import_limit_w;
    assign ran         = since_on >= cfg.min_run_ms;

    always_comb
    begin
        requested_next         = requested_reg;
        surplus_start_next     = surplus_start_reg;
        switch_on_next         = switch_on_reg;
        last_balance_time_next = last_balance_time_reg;
        last_balance_next      = last_balance_reg;
        last_temp_next         = last_temp_reg;
        result.relay_cmd       = CMD_NONE;
        result.cause           = CAUSE_NONE;

        unique case (ev.kind)
            KIND_BALANCE, KIND_TEMP:
            begin
                if (ev.kind == KIND_BALANCE)
                begin
                    last_balance_time_next = ev.now_ms;
                    last_balance_next      = ev.value;
                end
                else
                begin
                    last_temp_next = ev.value;
                end

                if (!requested_reg)
                begin
                    if (surplus)
                    begin
                        surplus_start_next = start;
                        if (since_start >= cfg.confirm_time_ms &&
                            temp <= cfg.max_temp_centi)
                        begin
                            requested_next   = 1'b1;
                            switch_on_next   = ev.now_ms;
                            result.relay_cmd = CMD_ON;
                            result.cause     = CAUSE_ON;
                        end
                    end
                    else
                    begin
                        surplus_start_next = 32'd0;
                    end
                end
                else if (ran && (hot || importing))
                begin
                    requested_next   = 1'b0;
                    result.relay_cmd = CMD_OFF;
                    priority if (hot && importing)
                        result.cause = CAUSE_BOTH;
                    else if (hot)
                        result.cause = CAUSE_TEMP;
                    else
                        result.cause = CAUSE_IMPORT;
                end
            end
            KIND_TICK:
            begin
                // gap must exceed the watchdog time strictly
                if (requested_reg && since_balance > cfg.watchdog_ms && ran)
                begin
                    requested_next     = 1'b0;
                    surplus_start_next = 32'd0;
                    result.relay_cmd   = CMD_OFF;
                    result.cause       = CAUSE_WATCHDOG;
                end
            end
            KIND_STOP:
            begin
                if (requested_reg)
                begin
                    requested_next   = 1'b0;
                    result.relay_cmd = CMD_OFF;
                    result.cause     = CAUSE_STOP;
                end
            end
            default:
            begin
                requested_next = requested_reg;
            end
        endcase

        result.heater_requested = requested_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            requested_reg         <= 1'b0;
            surplus_start_reg     <= 32'd0;
            switch_on_reg         <= 32'd0;
            last_balance_time_reg <= 32'd0;
            last_balance_reg      <= 32'sd0;
            last_temp_reg         <= 32'sd0;
        end
        else if (step)
        begin
            requested_reg         <= requested_next;
            surplus_start_reg     <= surplus_start_next;
            switch_on_reg         <= switch_on_next;
            last_balance_time_reg <= last_balance_time_next;
            last_balance_reg      <= last_balance_next;
            last_temp_reg         <= last_temp_next;
        end
    end

    assign requested = requested_reg;

endmodule

/* hdl/surplus_power_heater_enable.sv */
// Channel  Dir  Handshake          Payload
// -------  ---  -----------------  --------------------------------------------
// s_axis   in   s_tvalid/s_tready  tuser: kind; tdata: value, now_ms
// m_axis   out  m_tvalid/m_tready  tdata: relay_cmd, heater_requested, cause
// cfg      in   cfg_wr_en          cfg_index selects register, cfg_data value
//
// Each input transaction yields exactly one output transaction, via the input
// and output registers. One transaction per cycle is sustained while the
// output side is ready: the input register feeds the rule logic, whose result
// is captured in the output register in the same cycle the rule state updates.
// Reset (rst_n low, asynchronous) clears both pipeline valids, the rule state
// and loads the register defaults. A stalled output holds its result; the
// input register keeps accepting until it too is full.
module surplus_power_heater_enable (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] value, [63:32] now_ms
    input  logic [1:0]  s_tuser,   // [1:0] kind

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [1:0] relay_cmd, [2] heater_requested,
                                   // [5:3] cause, [7:6] zero

    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import sphe_pkg::*;

    cfg_t    cfg;
    event_t  in_reg;
    logic    in_valid_reg;
    result_t out_reg;
    logic    out_valid_reg;
    result_t result;
    logic    requested;
    logic    out_free;
    logic    advance;
    logic    in_take;

    sphe_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Rule state steps only when the held event moves into the output register.
    sphe_rule_core u_rule_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .step      (advance),
        .ev        (in_reg),
        .result    (result),
        .requested (requested)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    // Control: valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_reg.kind   <= kind_t'(s_tuser);
            in_reg.value  <= s_tdata[31:0];
            in_reg.now_ms <= s_tdata[63:32];
        end
        if (advance)
            out_reg <= result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.cause, out_reg.heater_requested, out_reg.relay_cmd};

    // An on command always leaves the heater requested.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.relay_cmd == CMD_ON |-> out_reg.heater_requested)
        else $error("on command without heater request");

    // An off command always leaves the heater released.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.relay_cmd == CMD_OFF |-> !out_reg.heater_requested)
        else $error("off command with heater still requested");

    // A cause is reported exactly when a command is given.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_reg.relay_cmd == CMD_NONE) == (out_reg.cause == CAUSE_NONE)))
        else $error("cause and command disagree");

    // The pending result reflects the current rule state.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.heater_requested == requested)
        else $error("result out of step with rule state");

    // The request can only rise along with an on command being issued.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(requested) |-> out_valid_reg && out_reg.relay_cmd == CMD_ON)
        else $error("request raised without on command");

endmodule

/* tb/tb_surplus_power_heater_enable.sv */
`timescale 1ns / 100ps

// Testbench for surplus_power_heater_enable.
// Events go in on the slave stream, one relay decision per event comes back on
// the master stream. A behavioral copy of the heater rule runs alongside and
// queues the decision it expects for every accepted event. The checker compares
// each returned transaction field by field against the oldest queued decision.
// Register writes only happen with the pipe drained.
module tb_surplus_power_heater_enable;
    import sphe_pkg::*;

    // Indexes past the last register; writes there must be dropped.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int IDLE_PCT     = 27;     // chance per cycle of a gap or stall
    localparam int SETTLE_LIMIT = 5000;   // cycles to wait for the pipe to drain
    localparam int PHASES       = 8;
    localparam int PHASE_EVENTS = 102;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;      // [31:0] value, [63:32] now_ms
    logic [1:0]  s_tuser   = '0;      // [1:0] kind
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;             // [1:0] relay_cmd, [2] heater_requested, [5:3] cause
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    // No gaps and no stalls on either side while set.
    logic        steady    = 1'b0;

    // Rule settings as the testbench believes them to be.
    int          surplus_thr;
    int          import_lim;
    int          temp_lim;
    int unsigned confirm_ms;
    int unsigned min_on_ms;
    int unsigned watchdog_lim;

    // Rule state mirror.
    logic        heater_on;
    logic [31:0] surplus_since;   // zero reads as no surplus seen yet
    logic [31:0] on_since;
    logic [31:0] last_bal_ms;
    int          last_bal;
    int          last_tmp;

    result_t     pending_results[$];
    result_t     want;
    logic [31:0] clock_ms;

    int          mismatches  = 0;
    int          events_sent = 0;
    int          results_seen = 0;
    int          relay_ons   = 0;
    int          relay_offs  = 0;
    int          reg_writes  = 0;

    surplus_power_heater_enable DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Heater rule: applies one event to the mirrored state and returns the
    // decision it produces. Time differences are 32-bit and wrap.
    function automatic result_t heater_rule(kind_t kind, int value, logic [31:0] now);
        result_t res;
        logic    hot;
        logic    importing;
        logic    ran;
        res.relay_cmd = CMD_NONE;
        res.cause     = CAUSE_NONE;
        case (kind)
            KIND_BALANCE:
            begin
                last_bal_ms = now;
                last_bal    = value;
            end
            KIND_TEMP:
                last_tmp = value;
            KIND_TICK:
            begin
                // gap must exceed the watchdog strictly, min on time still applies
                if (heater_on && (now - last_bal_ms) > watchdog_lim
                        && (now - on_since) >= min_on_ms)
                begin
                    heater_on     = 1'b0;
                    surplus_since = '0;
                    res.relay_cmd = CMD_OFF;
                    res.cause     = CAUSE_WATCHDOG;
                end
            end
            default:
            begin
                if (heater_on)
                begin
                    heater_on     = 1'b0;
                    res.relay_cmd = CMD_OFF;
                    res.cause     = CAUSE_STOP;
                end
            end
        endcase
        // Balance and temperature reports both re-run the on/off rule.
        if (kind == KIND_BALANCE || kind == KIND_TEMP)
        begin
            if (!heater_on)
            begin
                if (last_bal <= surplus_thr)
                begin
                    // a start taken at time zero stays "not started"
                    if (surplus_since == '0)
                        surplus_since = now;
                    if ((now - surplus_since) >= confirm_ms && last_tmp <= temp_lim)
                    begin
                        heater_on     = 1'b1;
                        on_since      = now;
                        res.relay_cmd = CMD_ON;
                        res.cause     = CAUSE_ON;
                    end
                end
                else
                    surplus_since = '0;
            end
            else
            begin
                hot       = last_tmp >= temp_lim;
                importing = last_bal >= import_lim;
                ran       = (now - on_since) >= min_on_ms;
                // rule switch off keeps the surplus start time
                if (ran && (hot || importing))
                begin
                    heater_on     = 1'b0;
                    res.relay_cmd = CMD_OFF;
                    if (hot && importing)
                        res.cause = CAUSE_BOTH;
                    else if (hot)
                        res.cause = CAUSE_TEMP;
                    else
                        res.cause = CAUSE_IMPORT;
                end
            end
        end
        res.heater_requested = heater_on;
        return res;
    endfunction

    // One event transaction. Entered and left at a falling edge; tvalid stays
    // high on return so back-to-back events never drop it within one step.
    task automatic send_event(kind_t kind, logic [31:0] value, logic [31:0] now);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {now, value};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(heater_rule(kind, value, now));
        events_sent++;
        @(negedge clk);
    endtask

    // Drops tvalid and waits for every queued decision to come back.
    task automatic settle();
        int waited;
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_results.size() != 0 && waited < SETTLE_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            mismatches++;
            pending_results.delete();
        end
        // pipe is two deep; give it room past the last transaction
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, logic [31:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
        reg_writes++;
        case (index)
            REG_SURPLUS_THRESHOLD: surplus_thr  = data;
            REG_IMPORT_LIMIT:      import_lim   = data;
            REG_MAX_TEMP:          temp_lim     = data;
            REG_CONFIRM_TIME:      confirm_ms   = data;
            REG_MIN_RUN:           min_on_ms    = data;
            REG_WATCHDOG:          watchdog_lim = data;
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic [31:0] threshold, logic [31:0] limit,
                                  logic [31:0] temp_max, logic [31:0] confirm,
                                  logic [31:0] min_on, logic [31:0] gap);
        settle();
        write_reg(REG_SURPLUS_THRESHOLD, threshold);
        write_reg(REG_IMPORT_LIMIT, limit);
        write_reg(REG_MAX_TEMP, temp_max);
        write_reg(REG_CONFIRM_TIME, confirm);
        write_reg(REG_MIN_RUN, min_on);
        write_reg(REG_WATCHDOG, gap);
    endtask

    // Mostly plausible reports clustered near the current limits so the rule
    // actually toggles; the rest is full-range noise and clock jumps.
    task automatic send_random_event();
        int    pick;
        int    step;
        int    value;
        kind_t kind;
        pick  = $urandom_range(99);
        value = $urandom;
        if (pick < 45)
        begin
            kind = KIND_BALANCE;
            if ($urandom_range(99) < 85)
                value = ($urandom_range(1) ? surplus_thr : import_lim)
                        + int'($urandom_range(80)) - 40;
        end
        else if (pick < 70)
        begin
            kind = KIND_TEMP;
            if ($urandom_range(99) < 85)
                value = temp_lim + int'($urandom_range(60)) - 30;
        end
        else if (pick < 90)
            kind = KIND_TICK;
        else
            kind = KIND_STOP;
        step = $urandom_range(99);
        if (step < 90)
            clock_ms += $urandom_range(15);
        else if (step < 97)
            clock_ms += $urandom_range(500);
        else
            clock_ms = $urandom;
        send_event(kind, value, clock_ms);
    endtask

    // Reset settings: idle stop and tick, start at time zero, confirmation
    // edge, temperature block, watchdog off, stop while running.
    task automatic test_reset_defaults();
        send_event(KIND_STOP,    32'd0,        32'd5);
        send_event(KIND_TICK,    32'd0,        32'd10);
        send_event(KIND_BALANCE, -32'sd1000,   32'd0);
        send_event(KIND_BALANCE, -32'sd1000,   32'd100);
        send_event(KIND_TEMP,    32'sd5500,    32'd300099);
        send_event(KIND_TEMP,    32'sd5500,    32'd300100);
        send_event(KIND_BALANCE, 32'sd200,     32'd300200);
        send_event(KIND_TICK,    32'd0,        32'd900100);
        send_event(KIND_BALANCE, -32'sd2000,   32'd900200);
        send_event(KIND_TEMP,    32'sd5501,    32'd1200200);
        send_event(KIND_TEMP,    32'sd5500,    32'd1200300);
        send_event(KIND_STOP,    32'hFFFF_FFFF, 32'd1200301);
    endtask

    // Field and register extremes, including the temperature-and-import cause.
    task automatic test_field_extremes();
        apply_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'd0, 32'd0, 32'hFFFF_FFFF);
        send_event(KIND_BALANCE, 32'h8000_0000, 32'hFFFF_FFFF);
        send_event(KIND_BALANCE, 32'h7FFF_FFFF, 32'd0);
        send_event(KIND_TEMP,    32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_event(KIND_TICK,    32'hFFFF_FFFF, 32'h8000_0000);
        send_event(KIND_STOP,    32'h5A5A_A5A5, 32'h1234_5678);
        apply_settings(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                       32'd0, 32'd0, 32'hFFFF_FFFF);
        send_event(KIND_TEMP,    32'h8000_0000, 32'd10);
        send_event(KIND_BALANCE, 32'd0,         32'd11);
    endtask

    // Watchdog boundary: a gap equal to the limit is fine, one more trips it.
    task automatic test_watchdog();
        apply_settings(32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 32'd5, 32'd10);
        send_event(KIND_BALANCE, -32'sd1, 32'd1000);
        send_event(KIND_TICK,    32'd0,   32'd1004);
        send_event(KIND_TICK,    32'd0,   32'd1010);
        send_event(KIND_TICK,    32'd0,   32'd1011);
        send_event(KIND_BALANCE, -32'sd1, 32'd1100);
    endtask

    // Random events under a series of settings: all-minimum, all-maximum,
    // then small windows where the relay cycles often.
    task automatic test_random_phases();
        int thr;
        clock_ms = 32'd2000;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0)
                apply_settings(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                               32'd0, 32'd0, 32'd0);
            else if (phase == 1)
                apply_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            else
            begin
                thr = int'($urandom_range(100)) - 50;
                apply_settings(thr, thr + int'($urandom_range(100)),
                               int'($urandom_range(100)) - 50,
                               $urandom_range(40), $urandom_range(40), $urandom_range(30));
            end
            if (phase == 3)
            begin
                write_reg(REG_SPARE_LO, $urandom);
                write_reg(REG_SPARE_HI, $urandom);
            end
            repeat (PHASE_EVENTS) send_random_event();
        end
    endtask

    // Full rate both ways, no gaps, no stalls.
    task automatic test_back_to_back();
        settle();
        steady = 1'b1;
        repeat (80) send_random_event();
        settle();
        steady = 1'b0;
    endtask

    // Output side back-pressure.
    always @(negedge clk)
    begin
        if (steady)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(99) >= IDLE_PCT);
    end

    // Result checker: every output transaction is matched against the oldest
    // queued decision.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (m_tdata[1:0] == CMD_ON)
                relay_ons++;
            if (m_tdata[1:0] == CMD_OFF)
                relay_offs++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result transaction, tdata %h", m_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tdata[1:0] !== want.relay_cmd)
                begin
                    $error("relay_cmd: expected %0d, actual %0d", want.relay_cmd, m_tdata[1:0]);
                    mismatches++;
                end
                if (m_tdata[2] !== want.heater_requested)
                begin
                    $error("heater_requested: expected %0d, actual %0d",
                           want.heater_requested, m_tdata[2]);
                    mismatches++;
                end
                if (m_tdata[5:3] !== want.cause)
                begin
                    $error("cause: expected %0d, actual %0d", want.cause, m_tdata[5:3]);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        surplus_thr   = CFG_RESET.surplus_threshold_w;
        import_lim    = CFG_RESET.import_limit_w;
        temp_lim      = CFG_RESET.max_temp_centi;
        confirm_ms    = CFG_RESET.confirm_time_ms;
        min_on_ms     = CFG_RESET.min_run_ms;
        watchdog_lim  = CFG_RESET.watchdog_ms;
        heater_on     = 1'b0;
        surplus_since = '0;
        on_since      = '0;
        last_bal_ms   = '0;
        last_bal      = 0;
        last_tmp      = 0;
        clock_ms      = '0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        test_reset_defaults();
        test_field_extremes();
        test_watchdog();
        test_random_phases();
        test_back_to_back();

        // catch any stray transaction after the last expected one
        settle();
        repeat (10) @(negedge clk);

        $display("covered %0d events and %0d register writes over %0d settings",
                 events_sent, reg_writes, PHASES + 4);
        $display("checked %0d results: %0d relay on, %0d relay off, %0d mismatches",
                 results_seen, relay_ons, relay_offs, mismatches);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Hang guard, far beyond the slowest legal run.
    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
